// ===== hdl/rag_pkg.sv =====
// Package for the rotate address generator: widths, field positions and
// register codes shared by the top level and its port checker.
// No dependencies.
package rag_pkg;

  // Arithmetic configuration.
  localparam int FRACTION_BITS = 14;
  localparam int MAX_DIMENSION = 2048;
  localparam int BOX_LIMIT     = 4095;

  // Field widths.
  localparam int DIM_W    = 12;                  // source width and height
  localparam int COEF_W   = 16;                  // cosine and sine
  localparam int BOX_W    = 12;                  // target box sizes and input offsets
  localparam int SIDX_W   = 22;
  localparam int TIDX_W   = 24;

  // Internal widths.
  localparam int BPROD_W  = DIM_W + COEF_W;      // size times absolute coefficient
  localparam int BSUM_W   = BPROD_W + 1;
  localparam int BSH_W    = BSUM_W - FRACTION_BITS;
  localparam int X1_W     = BOX_W + 2;           // centred target coordinate
  localparam int RPROD_W  = X1_W + COEF_W;
  localparam int ROT_W    = RPROD_W + 1;
  localparam int COORD_W  = ROT_W - FRACTION_BITS;
  localparam int OFF_W    = COORD_W + 1;
  localparam int SPROD_W  = 2 * DIM_W;
  localparam int TPROD_W  = 2 * BOX_W;

  // Stream packing.
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 2;
  localparam int SIDX_LSB    = 0;
  localparam int TIDX_LSB    = SIDX_LSB + SIDX_W;
  localparam int TW_LSB      = TIDX_LSB + TIDX_W;
  localparam int TH_LSB      = TW_LSB + BOX_W;
  localparam int PAD_W       = OUT_TDATA_W - (TH_LSB + BOX_W);
  localparam int TUSER_HIT    = 0;
  localparam int TUSER_INSIDE = 1;

  // Configuration port.
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam int NUM_STAGES = 10;

  typedef enum logic [1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_COSINE        = 2'd2,
    REG_SINE          = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [BOX_W-1:0] tw;
    logic [BOX_W-1:0] th;
  } box_t;

endpackage

// ===== hdl/rotate_address_generator.sv =====
// Rotate address generator: maps a target pixel of a centre-rotated image to
// its source pixel and gives both linear indices. Depends on rag_pkg.
// An accepted input beat passes through stage registers 0 to 9 to its output beat.
// Throughput: one beat per cycle while the output is not stalled; every one of the ten
// stages carries a valid bit and loads whenever it is empty or the stage after it moves on.
// Reset clears all valid bits and sets the registers to width 1, height 1,
// cosine 1.0 and sine 0.
module rotate_address_generator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rag_pkg::APB_AW-1:0]      paddr,
  input  logic [rag_pkg::APB_DW-1:0]      pwdata,
  output logic [rag_pkg::APB_DW-1:0]      prdata,
  output logic                            pready,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: target_column[11:0], target_row[23:12]
  input  logic [rag_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // Output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: source_index[21:0], target_index[45:22], target_width[57:46],
  // target_height[69:58], zero padding[71:70]
  output logic [rag_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: source_hit[0], inside_target[1]
  output logic [rag_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
  import rag_pkg::*;

  localparam int NS = NUM_STAGES;

  // Configuration registers
  logic        [DIM_W-1:0]  src_w_q, src_h_q;
  logic signed [COEF_W-1:0] cos_q, sin_q;

  logic        [DIM_W-1:0]  w_sat, h_sat;
  logic        [COEF_W-1:0] abs_cos, abs_sin;
  reg_idx_e                 rd_idx;

  // Pipeline control
  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  // Stage registers
  logic [BOX_W-1:0]   col0_q, row0_q, col1_q, row1_q, col2_q, col3_q;
  logic [BPROD_W-1:0] pwc0_q, phs0_q, phc0_q, pws0_q;
  box_t               box_q [1:NS-1];
  logic               inside_q [2:NS-1];
  logic [TIDX_W-1:0]  tidx_q [4:NS-1];
  logic signed [X1_W-1:0]    x1_2_q, y1_2_q;
  logic [BOX_W-1:0]          trow2_q;
  logic signed [RPROD_W-1:0] pxc3_q, pys3_q, pxs3_q, pyc3_q;
  logic [TPROD_W-1:0]        tprod3_q;
  logic signed [ROT_W-1:0]   xs4_q, ys4_q;
  logic signed [COORD_W-1:0] x5_q, y5_q;
  logic signed [OFF_W-1:0]   xo6_q, yo6_q;
  logic                      hit7_q, hit8_q, hit9_q;
  logic [DIM_W-1:0]          srow7_q, xo7_q, xo8_q;
  logic [SPROD_W-1:0]        sprod8_q;
  logic [SIDX_W-1:0]         sidx9_q;

  // Combinational stage inputs
  box_t                      box1_d;
  logic [BSUM_W-1:0]         wsum, hsum;
  logic [BSH_W-1:0]          wsh, hsh;
  logic signed [ROT_W-1:0]   xbias, ybias, xsb, ysb;
  logic signed [OFF_W-1:0]   w_ext, h_ext, srow_full;
  logic                      x_ok, y_ok;
  logic [SPROD_W-1:0]        ssum;
  logic [TPROD_W-1:0]        tsum;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign rd_idx = reg_idx_e'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= DIM_W'(1);
      src_h_q <= DIM_W'(1);
      cos_q   <= COEF_W'(1 << FRACTION_BITS);
      sin_q   <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (rd_idx)
        REG_SOURCE_WIDTH:  src_w_q <= pwdata[DIM_W-1:0];
        REG_SOURCE_HEIGHT: src_h_q <= pwdata[DIM_W-1:0];
        REG_COSINE:        cos_q   <= pwdata[COEF_W-1:0];
        REG_SINE:          sin_q   <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (rd_idx)
      REG_SOURCE_WIDTH:  prdata = APB_DW'(src_w_q);
      REG_SOURCE_HEIGHT: prdata = APB_DW'(src_h_q);
      REG_COSINE:        prdata = {{(APB_DW-COEF_W){1'b0}}, cos_q};
      REG_SINE:          prdata = {{(APB_DW-COEF_W){1'b0}}, sin_q};
      default:           prdata = '0;
    endcase
  end

  // Sizes above the maximum are clamped; the coefficient magnitude is taken at
  // full width, so the most negative code becomes 2.0.
  assign w_sat   = ({1'b0, src_w_q} > (DIM_W+1)'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION)
                                                                  : src_w_q;
  assign h_sat   = ({1'b0, src_h_q} > (DIM_W+1)'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION)
                                                                  : src_h_q;
  assign abs_cos = cos_q[COEF_W-1] ? COEF_W'(-cos_q) : COEF_W'(cos_q);
  assign abs_sin = sin_q[COEF_W-1] ? COEF_W'(-sin_q) : COEF_W'(sin_q);

  // ---------------------------------------------------------------------------
  // Handshake: a stage loads when it is empty or its successor loads.
  // ---------------------------------------------------------------------------
  always_comb begin
    en[NS-1] = !v_q[NS-1] || m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  assign wsum   = {1'b0, pwc0_q} + {1'b0, phs0_q};
  assign hsum   = {1'b0, phc0_q} + {1'b0, pws0_q};
  assign wsh    = wsum[BSUM_W-1:FRACTION_BITS];
  assign hsh    = hsum[BSUM_W-1:FRACTION_BITS];
  assign box1_d.tw = (wsh > BSH_W'(BOX_LIMIT)) ? BOX_W'(BOX_LIMIT) : wsh[BOX_W-1:0];
  assign box1_d.th = (hsh > BSH_W'(BOX_LIMIT)) ? BOX_W'(BOX_LIMIT) : hsh[BOX_W-1:0];

  // Truncation toward zero: negative sums get a bias of one below the divisor.
  assign xbias = xs4_q[ROT_W-1] ? ROT_W'((1 << FRACTION_BITS) - 1) : '0;
  assign ybias = ys4_q[ROT_W-1] ? ROT_W'((1 << FRACTION_BITS) - 1) : '0;
  assign xsb   = xs4_q + xbias;
  assign ysb   = ys4_q + ybias;

  assign w_ext     = $signed({{(OFF_W-DIM_W){1'b0}}, w_sat});
  assign h_ext     = $signed({{(OFF_W-DIM_W){1'b0}}, h_sat});
  assign x_ok      = !xo6_q[OFF_W-1] && (xo6_q < w_ext);
  assign y_ok      = !yo6_q[OFF_W-1] && (yo6_q < h_ext);
  assign srow_full = h_ext - yo6_q - OFF_W'(1);

  assign tsum = tprod3_q + {{(TPROD_W-BOX_W){1'b0}}, col3_q};
  assign ssum = sprod8_q + {{(SPROD_W-DIM_W){1'b0}}, xo8_q};

  always_ff @(posedge clk_i) begin
    // Stage 0: bounding box products
    if (en[0]) begin
      col0_q <= s_axis_tdata[BOX_W-1:0];
      row0_q <= s_axis_tdata[2*BOX_W-1:BOX_W];
      pwc0_q <= w_sat * abs_cos;
      phs0_q <= h_sat * abs_sin;
      phc0_q <= h_sat * abs_cos;
      pws0_q <= w_sat * abs_sin;
    end
    // Stage 1: box sizes
    if (en[1]) begin
      col1_q   <= col0_q;
      row1_q   <= row0_q;
      box_q[1] <= box1_d;
    end
    // Stage 2: range check and centring
    if (en[2]) begin
      col2_q      <= col1_q;
      inside_q[2] <= (col1_q < box_q[1].tw) && (row1_q < box_q[1].th);
      x1_2_q      <= $signed({2'b00, col1_q}) - $signed({3'b000, box_q[1].tw[BOX_W-1:1]});
      y1_2_q      <= $signed({2'b00, row1_q}) - $signed({3'b000, box_q[1].th[BOX_W-1:1]});
      trow2_q     <= box_q[1].th - row1_q - BOX_W'(1);
    end
    // Stage 3: rotation and target row products
    if (en[3]) begin
      col3_q   <= col2_q;
      pxc3_q   <= x1_2_q * cos_q;
      pys3_q   <= y1_2_q * sin_q;
      pxs3_q   <= x1_2_q * sin_q;
      pyc3_q   <= y1_2_q * cos_q;
      tprod3_q <= trow2_q * box_q[2].tw;
    end
    // Stage 4: rotation sums and target index
    if (en[4]) begin
      xs4_q     <= ROT_W'(pxc3_q) - ROT_W'(pys3_q);
      ys4_q     <= ROT_W'(pxs3_q) + ROT_W'(pyc3_q);
      tidx_q[4] <= inside_q[3] ? tsum : '0;
    end
    // Stage 5: scale back
    if (en[5]) begin
      x5_q <= xsb[ROT_W-1:FRACTION_BITS];
      y5_q <= ysb[ROT_W-1:FRACTION_BITS];
    end
    // Stage 6: source offsets from the lower left corner
    if (en[6]) begin
      xo6_q <= OFF_W'(x5_q) + $signed({{(OFF_W-DIM_W+1){1'b0}}, w_sat[DIM_W-1:1]});
      yo6_q <= OFF_W'(y5_q) + $signed({{(OFF_W-DIM_W+1){1'b0}}, h_sat[DIM_W-1:1]});
    end
    // Stage 7: hit test
    if (en[7]) begin
      hit7_q  <= inside_q[6] && x_ok && y_ok;
      srow7_q <= srow_full[DIM_W-1:0];
      xo7_q   <= xo6_q[DIM_W-1:0];
    end
    // Stage 8: source row product
    if (en[8]) begin
      hit8_q   <= hit7_q;
      xo8_q    <= xo7_q;
      sprod8_q <= srow7_q * w_sat;
    end
    // Stage 9: source index, output register
    if (en[9]) begin
      hit9_q  <= hit8_q;
      sidx9_q <= hit8_q ? ssum[SIDX_W-1:0] : '0;
    end
    // Values that ride along unchanged
    for (int k = 2; k < NS; k++) begin
      if (en[k]) begin
        box_q[k] <= box_q[k-1];
      end
    end
    for (int k = 3; k < NS; k++) begin
      if (en[k]) begin
        inside_q[k] <= inside_q[k-1];
      end
    end
    for (int k = 5; k < NS; k++) begin
      if (en[k]) begin
        tidx_q[k] <= tidx_q[k-1];
      end
    end
  end

  assign m_axis_tdata = {{PAD_W{1'b0}}, box_q[NS-1].th, box_q[NS-1].tw,
                         tidx_q[NS-1], sidx9_q};
  assign m_axis_tuser = {inside_q[NS-1], hit9_q};

endmodule

// ===== hdl/rag_checker.sv =====
// Port checker for the rotate address generator, attached by bind.
// Depends on rag_pkg for the output field positions.
module rag_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [rag_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [rag_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
  import rag_pkg::*;

  logic [SIDX_W-1:0] sidx;
  logic [TIDX_W-1:0] tidx;
  logic [BOX_W-1:0]  tw, th;
  logic              hit, in_box;

  assign sidx   = m_axis_tdata[TIDX_LSB-1:SIDX_LSB];
  assign tidx   = m_axis_tdata[TW_LSB-1:TIDX_LSB];
  assign tw     = m_axis_tdata[TH_LSB-1:TW_LSB];
  assign th     = m_axis_tdata[TH_LSB+BOX_W-1:TH_LSB];
  assign hit    = m_axis_tuser[TUSER_HIT];
  assign in_box = m_axis_tuser[TUSER_INSIDE];

  // A stalled output beat is held until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // A source hit is only possible for a position inside the box.
  a_hit_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && hit |-> in_box)
    else $error("source hit outside the target box");

  // A miss leaves the source index at zero.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !hit |-> sidx == '0)
    else $error("non-zero source index without a hit");

  // Outside the box the target index is zero (the source index is covered by the miss check).
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !in_box |-> tidx == '0)
    else $error("non-zero target index outside the box");

  // A position inside the box needs a box of non-zero size.
  a_box_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && in_box |-> tw != '0 && th != '0)
    else $error("inside flag with an empty box");

endmodule

bind rotate_address_generator rag_checker u_rag_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
